// ----- hdl/mac_learning_forward_decision_macros.svh -----
// assertion macros for the mac learning forwarding block
// used by the top level only, no other dependencies
`ifndef MAC_LEARNING_FORWARD_DECISION_MACROS_SVH
`define MAC_LEARNING_FORWARD_DECISION_MACROS_SVH

// same-cycle implication, disabled in reset
`define MLFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define MLFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/mlfd_pkg.sv -----
// shared types and constants for the mac learning forwarding block
// no dependencies
package mlfd_pkg;

  localparam int MAC_W       = 48;
  localparam int PORT_W      = 3;
  localparam int MASK_W      = 8;
  localparam int CNT_W       = 4;
  localparam int TABLE_DEPTH = 64;
  localparam int MAX_PORTS   = 8;
  localparam int PORT_LIM    = (MAX_PORTS < MASK_W) ? MAX_PORTS : MASK_W;
  localparam logic [CNT_W-1:0] ACTIVE_PORTS_RST = CNT_W'(8);

  typedef struct packed {
    logic              vld;
    logic [MAC_W-1:0]  src_mac;
    logic [MAC_W-1:0]  dst_mac;
    logic [PORT_W-1:0] ingress_port;
    logic              src_found;
    logic              learned;
    logic              dst_hit;
    logic [PORT_W-1:0] hit_port;
  } query_t;

endpackage

// ----- hdl/mlfd_ifs.sv -----
// handshake channel interfaces for frame headers and forwarding results
// depends on mlfd_pkg
interface mlfd_in_if;
  import mlfd_pkg::*;
  logic              valid;
  logic              ready;
  logic [MAC_W-1:0]  src_mac;
  logic [MAC_W-1:0]  dst_mac;
  logic [PORT_W-1:0] ingress_port;
  modport source(output valid, output src_mac, output dst_mac, output ingress_port,
                 input ready);
  modport sink(input valid, input src_mac, input dst_mac, input ingress_port,
               output ready);
endinterface

interface mlfd_out_if;
  import mlfd_pkg::*;
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] port_mask;
  logic              dst_hit;
  logic              learned;
  logic              table_full;
  modport source(output valid, output port_mask, output dst_hit, output learned,
                 output table_full, input ready);
  modport sink(input valid, input port_mask, input dst_hit, input learned,
               input table_full, output ready);
endinterface

// ----- hdl/mlfd_cell.sv -----
// one table cell: holds one learned address and port, compares the passing item
// depends on mlfd_pkg
module mlfd_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  mlfd_pkg::query_t q_in,
  output mlfd_pkg::query_t q_out,
  output logic            ent_vld
);
  import mlfd_pkg::*;

  logic              ent_vld_r;
  logic [MAC_W-1:0]  ent_mac_r;
  logic [PORT_W-1:0] ent_port_r;
  query_t            q_r;
  query_t            q_nxt;

  logic              learn;
  logic              eff_vld;
  logic [MAC_W-1:0]  eff_mac;
  logic [PORT_W-1:0] eff_port;

  assign learn    = q_in.vld && !q_in.src_found && !ent_vld_r;
  assign eff_vld  = ent_vld_r || learn;
  assign eff_mac  = learn ? q_in.src_mac : ent_mac_r;
  assign eff_port = learn ? q_in.ingress_port : ent_port_r;

  always_comb begin
    q_nxt = q_in;
    if (ent_vld_r && (ent_mac_r == q_in.src_mac)) begin
      q_nxt.src_found = 1'b1;
    end
    if (learn) begin
      q_nxt.src_found = 1'b1;
      q_nxt.learned   = 1'b1;
    end
    if (eff_vld && !q_in.dst_hit && (eff_mac == q_in.dst_mac)) begin
      q_nxt.dst_hit  = 1'b1;
      q_nxt.hit_port = eff_port;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= 1'b0;
      q_r.vld   <= 1'b0;
    end else if (adv) begin
      q_r <= q_nxt;
      if (learn) begin
        ent_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (learn) begin
        ent_mac_r  <= q_in.src_mac;
        ent_port_r <= q_in.ingress_port;
      end
    end
  end

  assign q_out   = q_r;
  assign ent_vld = ent_vld_r;

endmodule

// ----- hdl/mlfd_out_stage.sv -----
// result register: builds the port mask from the finished item and holds it
// depends on mlfd_pkg
module mlfd_out_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mlfd_pkg::query_t           q_in,
  input  logic [mlfd_pkg::CNT_W-1:0] active_ports,
  output logic                       adv,
  mlfd_out_if.source                 out_ch
);
  import mlfd_pkg::*;

  logic              out_valid_r;
  logic [MASK_W-1:0] port_mask_r;
  logic [MASK_W-1:0] port_mask_nxt;
  logic              dst_hit_r;
  logic              learned_r;
  logic              table_full_r;
  logic [CNT_W-1:0]  lim;
  logic [MASK_W:0]   all_ports;

  assign adv = !out_valid_r || out_ch.ready;

  assign lim       = (active_ports > CNT_W'(PORT_LIM)) ? CNT_W'(PORT_LIM) : active_ports;
  assign all_ports = ((MASK_W+1)'(1) << lim) - (MASK_W+1)'(1);

  always_comb begin
    if (q_in.dst_hit) begin
      port_mask_nxt = MASK_W'(1) << q_in.hit_port;
    end else begin
      port_mask_nxt = all_ports[MASK_W-1:0] & ~(MASK_W'(1) << q_in.ingress_port);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= q_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      port_mask_r  <= port_mask_nxt;
      dst_hit_r    <= q_in.dst_hit;
      learned_r    <= q_in.learned;
      table_full_r <= !q_in.src_found;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.port_mask  = port_mask_r;
  assign out_ch.dst_hit    = dst_hit_r;
  assign out_ch.learned    = learned_r;
  assign out_ch.table_full = table_full_r;

endmodule

// ----- hdl/mac_learning_forward_decision.sv -----
// Ethernet mac learning and forwarding decision. Each frame header item walks
// a row of TABLE_DEPTH cells, one cell per cycle while the row is not stalled;
// each cell holds one learned address with its port, learns the source in the
// first empty cell when it was not seen earlier, and checks the destination.
// One item is taken every cycle while the result side keeps up; each item passes
// through the register of every cell and then the result register. The cell row
// and the result register stall together while a result waits. Depends on
// mlfd_pkg, mlfd_ifs, mlfd_cell, mlfd_out_stage and the assertion macro header.
`include "mac_learning_forward_decision_macros.svh"

module mac_learning_forward_decision #(
  parameter int TABLE_DEPTH = mlfd_pkg::TABLE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [mlfd_pkg::CNT_W-1:0] cfg_wdata,
  mlfd_in_if.sink                    in_ch,
  mlfd_out_if.source                 out_ch
);
  import mlfd_pkg::*;

  logic [CNT_W-1:0]       active_ports_r;
  logic                   adv;
  query_t                 q [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] cell_vld;
  logic [TABLE_DEPTH:0]   vld_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_ports_r <= ACTIVE_PORTS_RST;
    end else if (cfg_we) begin
      active_ports_r <= cfg_wdata;
    end
  end

  assign in_ch.ready = adv;

  always_comb begin
    q[0].vld          = in_ch.valid;
    q[0].src_mac      = in_ch.src_mac;
    q[0].dst_mac      = in_ch.dst_mac;
    q[0].ingress_port = in_ch.ingress_port;
    q[0].src_found    = 1'b0;
    q[0].learned      = 1'b0;
    q[0].dst_hit      = 1'b0;
    q[0].hit_port     = '0;
  end

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    mlfd_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .q_in    (q[k]),
      .q_out   (q[k+1]),
      .ent_vld (cell_vld[k])
    );
  end

  mlfd_out_stage u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_in         (q[TABLE_DEPTH]),
    .active_ports (active_ports_r),
    .adv          (adv),
    .out_ch       (out_ch)
  );

  assign vld_inc = {1'b0, cell_vld} + (TABLE_DEPTH+1)'(1);

  // filled cells always form one run from the head of the row
  `MLFD_ASSERT_NOW(a_cells_packed, clk, rst_n, 1'b1, $onehot(vld_inc), "cell fill not contiguous")
  // the table does not change while the row is stalled
  `MLFD_ASSERT_NEXT(a_stall_holds, clk, rst_n, !adv, $stable(cell_vld), "table changed in stall")
  // an item is either learned, known or dropped for a full table
  `MLFD_ASSERT_NOW(a_learn_full, clk, rst_n, out_ch.valid,
    !(out_ch.learned && out_ch.table_full), "learned and table_full both set")
  // a hit sends to exactly one port
  `MLFD_ASSERT_NOW(a_hit_onehot, clk, rst_n, out_ch.valid && out_ch.dst_hit,
    $onehot(out_ch.port_mask), "hit mask not one port")

endmodule
